/* hdl/lphm_pkg.sv */
package lphm_pkg;

    localparam int CAPACITY_LOG2 = 10;
    localparam int SLOT_COUNT    = 1 << CAPACITY_LOG2;
    localparam int CNT_W         = CAPACITY_LOG2 + 1;
    localparam int OCC_W         = 11;
    localparam int MIN_SIZE_LOG2 = 4;
    localparam int PADDR_W       = 3;

    localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;
    localparam logic [0:0] REG_TABLE_SIZE  = 1'b0;

    // key + 1 + golden ratio increment, folded into one constant
    localparam logic [63:0] HASH_OFFSET = 64'h9e37_79b9_7f4a_7c16;
    localparam logic [63:0] MUL_C1      = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MUL_C2      = 64'h94d0_49bb_1331_11eb;
    localparam int SHIFT_1 = 30;
    localparam int SHIFT_2 = 27;
    localparam int SHIFT_3 = 31;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    typedef logic [CAPACITY_LOG2-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        KIND_PROBE,
        KIND_CLEAR,
        KIND_INVALID,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        insert;
        logic [63:0] key;
        logic [31:0] value;
        slot_idx_t   home;
    } work_t;

    typedef struct packed {
        logic             hit;
        logic [31:0]      found_value;
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
    } result_t;

    function automatic slot_idx_t probe_mask(input logic [3:0] size_log2);
        int        n;
        slot_idx_t m;
        n = int'(size_log2);
        if (n < MIN_SIZE_LOG2) n = MIN_SIZE_LOG2;
        if (n > CAPACITY_LOG2) n = CAPACITY_LOG2;
        for (int i = 0; i < CAPACITY_LOG2; i++)
        begin
            m[i] = (i < n);
        end
        return m;
    endfunction

endpackage

/* hdl/lphm_front.sv */
module lphm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          cmd,
    input  logic [63:0]         key,
    input  logic [31:0]         value,
    input  lphm_pkg::slot_idx_t mask,
    input  logic                hold,
    output logic                push_valid,
    input  logic                push_ready,
    output lphm_pkg::work_t     push_data
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL1,
        F_SUM1,
        F_MUL2,
        F_SUM2,
        F_PUSH
    } fstate_t;

    fstate_t             state_reg;
    lphm_pkg::kind_t     kind_reg;
    logic                insert_reg;
    logic [63:0]         key_reg;
    logic [31:0]         value_reg;
    logic [63:0]         x_reg;
    logic [63:0]         p0_reg;
    logic [31:0]         p1_reg;
    logic [31:0]         p2_reg;

    lphm_pkg::kind_t     kind_in;
    logic [63:0]         mix;
    logic [63:0]         mul_c;
    logic [63:0]         prod_ll;
    logic [31:0]         prod_lh;
    logic [31:0]         prod_hl;
    logic [31:0]         cross_sum;
    logic [63:0]         x_next;
    logic [63:0]         hash;
    logic                accept;

    assign s_ready = (state_reg == F_IDLE) && !hold;
    assign accept  = s_valid && s_ready;

    always_comb
    begin
        case (cmd)
            lphm_pkg::CMD_INSERT,
            lphm_pkg::CMD_LOOKUP:
                kind_in = (key == 64'hffff_ffff_ffff_ffff) ? lphm_pkg::KIND_INVALID
                                                            : lphm_pkg::KIND_PROBE;
            lphm_pkg::CMD_CLEAR:
                kind_in = lphm_pkg::KIND_CLEAR;
            default:
                kind_in = lphm_pkg::KIND_NOP;
        endcase
    end

    // one shared set of 32x32 partial products serves both finalizer rounds
    assign mix     = (state_reg == F_MUL1) ? (x_reg ^ (x_reg >> lphm_pkg::SHIFT_1))
                                           : (x_reg ^ (x_reg >> lphm_pkg::SHIFT_2));
    assign mul_c   = (state_reg == F_MUL1) ? lphm_pkg::MUL_C1 : lphm_pkg::MUL_C2;
    assign prod_ll = {32'h0, mix[31:0]} * {32'h0, mul_c[31:0]};
    assign prod_lh = mix[31:0] * mul_c[63:32];
    assign prod_hl = mix[63:32] * mul_c[31:0];

    assign cross_sum = p1_reg + p2_reg;
    assign x_next    = p0_reg + {cross_sum, 32'h0};
    assign hash      = x_reg ^ (x_reg >> lphm_pkg::SHIFT_3);

    assign push_valid       = (state_reg == F_PUSH);
    assign push_data.kind   = kind_reg;
    assign push_data.insert = insert_reg;
    assign push_data.key    = key_reg;
    assign push_data.value  = value_reg;
    assign push_data.home   = hash[lphm_pkg::CAPACITY_LOG2-1:0] & mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (kind_in == lphm_pkg::KIND_PROBE) ? F_MUL1 : F_PUSH;
                    end
                end
                F_MUL1: state_reg <= F_SUM1;
                F_SUM1: state_reg <= F_MUL2;
                F_MUL2: state_reg <= F_SUM2;
                F_SUM2: state_reg <= F_PUSH;
                F_PUSH:
                begin
                    if (push_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind_in;
            insert_reg <= (cmd == lphm_pkg::CMD_INSERT);
            key_reg    <= key;
            value_reg  <= value;
            x_reg      <= key + lphm_pkg::HASH_OFFSET;
        end
        else if (state_reg == F_SUM1 || state_reg == F_SUM2)
        begin
            x_reg <= x_next;
        end
        if (state_reg == F_MUL1 || state_reg == F_MUL2)
        begin
            p0_reg <= prod_ll;
            p1_reg <= prod_lh;
            p2_reg <= prod_hl;
        end
    end

endmodule

/* hdl/lphm_queue.sv */
module lphm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  lphm_pkg::work_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output lphm_pkg::work_t pop_data
);

    lphm_pkg::work_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      fill_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/lphm_back.sv */
module lphm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lphm_pkg::slot_idx_t mask,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  lphm_pkg::work_t     pop_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lphm_pkg::result_t   out_data,
    output logic                init_busy
);

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_ISSUE,
        B_CHECK
    } bstate_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [31:0] value;
    } slot_t;

    slot_t mem [lphm_pkg::SLOT_COUNT];
    slot_t rdata_reg;

    bstate_t                        state_reg;
    lphm_pkg::slot_idx_t            sweep_reg;
    logic                           resp_reg;
    logic [lphm_pkg::CNT_W-1:0]     count_reg;
    logic                           out_valid_reg;
    lphm_pkg::result_t              result_reg;
    lphm_pkg::work_t                item_reg;
    lphm_pkg::slot_idx_t            slot_reg;
    lphm_pkg::slot_idx_t            steps_reg;

    lphm_pkg::slot_idx_t            slot_next;
    lphm_pkg::slot_idx_t            rd_addr;
    lphm_pkg::slot_idx_t            wr_addr;
    slot_t                          wr_data;
    logic                           wr_en;
    logic                           key_match;
    logic [lphm_pkg::CNT_W-1:0]     cnt_inc;
    logic                           sweep_last;

    assign slot_next  = (slot_reg + lphm_pkg::slot_idx_t'(1)) & mask;
    assign rd_addr    = (state_reg == B_ISSUE) ? slot_reg : slot_next;
    assign key_match  = rdata_reg.valid && (rdata_reg.key == item_reg.key);
    assign cnt_inc    = count_reg + lphm_pkg::CNT_W'(1);
    assign sweep_last = (sweep_reg == {lphm_pkg::CAPACITY_LOG2{1'b1}});

    assign pop_ready = (state_reg == B_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;
    assign init_busy = (state_reg == B_CLEAR) && !resp_reg;

    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = slot_reg;
        wr_data.valid = 1'b1;
        wr_data.key   = item_reg.key;
        wr_data.value = item_reg.value;
        if (state_reg == B_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg;
            wr_data = '0;
        end
        else if (state_reg == B_CHECK && !rdata_reg.valid && item_reg.insert)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            sweep_reg     <= '0;
            resp_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
            item_reg      <= '0;
            slot_reg      <= '0;
            steps_reg     <= '0;
        end
        else
        begin
            // a transfer taken together with a new item is handled in B_IDLE
            if (out_valid_reg && out_ready && !(pop_valid && pop_ready))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR:
                begin
                    sweep_reg <= sweep_reg + lphm_pkg::slot_idx_t'(1);
                    if (sweep_last)
                    begin
                        state_reg <= B_IDLE;
                        if (resp_reg)
                        begin
                            out_valid_reg          <= 1'b1;
                            result_reg.hit         <= 1'b0;
                            result_reg.found_value <= '0;
                            result_reg.status      <= lphm_pkg::STATUS_OK;
                            result_reg.occupancy   <= '0;
                        end
                    end
                end
                B_IDLE:
                begin
                    if (pop_valid && pop_ready)
                    begin
                        item_reg               <= pop_data;
                        result_reg.hit         <= 1'b0;
                        result_reg.found_value <= '0;
                        result_reg.occupancy   <= lphm_pkg::OCC_W'(count_reg);
                        out_valid_reg          <= (pop_data.kind == lphm_pkg::KIND_INVALID) ||
                                                  (pop_data.kind == lphm_pkg::KIND_NOP);
                        case (pop_data.kind)
                            lphm_pkg::KIND_PROBE:
                            begin
                                slot_reg  <= pop_data.home;
                                steps_reg <= '0;
                                state_reg <= B_ISSUE;
                            end
                            lphm_pkg::KIND_CLEAR:
                            begin
                                sweep_reg <= '0;
                                resp_reg  <= 1'b1;
                                count_reg <= '0;
                                state_reg <= B_CLEAR;
                            end
                            lphm_pkg::KIND_INVALID:
                            begin
                                result_reg.status <= lphm_pkg::STATUS_INVALID;
                            end
                            default:
                            begin
                                result_reg.status <= lphm_pkg::STATUS_OK;
                            end
                        endcase
                    end
                end
                B_ISSUE:
                begin
                    state_reg <= B_CHECK;
                end
                B_CHECK:
                begin
                    if (!rdata_reg.valid)
                    begin
                        // empty slot ends the probe; insert claims it
                        result_reg.status <= lphm_pkg::STATUS_OK;
                        if (item_reg.insert)
                        begin
                            count_reg            <= cnt_inc;
                            result_reg.occupancy <= lphm_pkg::OCC_W'(cnt_inc);
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                    else if (key_match)
                    begin
                        result_reg.hit         <= 1'b1;
                        result_reg.found_value <= rdata_reg.value;
                        result_reg.status      <= lphm_pkg::STATUS_OK;
                        out_valid_reg          <= 1'b1;
                        state_reg              <= B_IDLE;
                    end
                    else if (steps_reg == mask)
                    begin
                        // one full pass without a free slot
                        result_reg.status <= item_reg.insert ? lphm_pkg::STATUS_FULL
                                                             : lphm_pkg::STATUS_OK;
                        out_valid_reg     <= 1'b1;
                        state_reg         <= B_IDLE;
                    end
                    else
                    begin
                        slot_reg  <= slot_next;
                        steps_reg <= steps_reg + lphm_pkg::slot_idx_t'(1);
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

/* hdl/linear_probe_hash_map_unit.sv */
// Channel   Dir  Transfer when              Payload
// s_*       in   s_tvalid & s_tready         tdata: key, value; tuser: cmd
// m_*       out  m_tvalid & m_tready         tdata: found_value, occupancy;
//                                            tuser: hit, status
// APB       in   psel & penable & pwrite     reg 0 at 0x0: table_size_log2
//
// Front: accepts a command, hashes a lookup or insert on a shared 32x32 multiplier
// set through states F_MUL1, F_SUM1, F_MUL2 and F_SUM2, then pushes it; it takes
// no new command until the last one is pushed. Back: reads each probed slot on
// the slot memory read port. A clear sweeps all 2^CAPACITY_LOG2 slots (1024); the
// same sweep runs after reset, with s_tready low. A two-entry queue lets the front
// keep hashing while the back probes or waits on m_tready.
module linear_probe_hash_map_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [95:0]                  s_tdata,   // key[63:0], value[95:64]
    input  logic [1:0]                   s_tuser,   // cmd[1:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata,   // found_value[31:0], occupancy[42:32]
    output logic [2:0]                   m_tuser,   // hit[0], status[2:1]
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lphm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [3:0]          size_log2_reg;
    lphm_pkg::slot_idx_t mask;
    logic                reg_sel;
    logic                hold;
    logic                push_valid;
    logic                push_ready;
    lphm_pkg::work_t     push_data;
    logic                pop_valid;
    logic                pop_ready;
    lphm_pkg::work_t     pop_data;
    lphm_pkg::result_t   result;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[lphm_pkg::PADDR_W-1:2] == lphm_pkg::REG_TABLE_SIZE);
    assign prdata  = reg_sel ? {28'h0, size_log2_reg} : 32'h0;
    assign mask    = lphm_pkg::probe_mask(size_log2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= lphm_pkg::SIZE_LOG2_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            size_log2_reg <= pwdata[3:0];
        end
    end

    lphm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .cmd        (s_tuser),
        .key        (s_tdata[63:0]),
        .value      (s_tdata[95:64]),
        .mask       (mask),
        .hold       (hold),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lphm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lphm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mask       (mask),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (result),
        .init_busy  (hold)
    );

    assign m_tdata = {5'h0, result.occupancy, result.found_value};
    assign m_tuser = {result.status, result.hit};

endmodule
